/* rtl/core/segment_box_overlap_test_macros.svh */
// Assertion macros used by the segment/box overlap test top level.
`ifndef SEGMENT_BOX_OVERLAP_TEST_MACROS_SVH
`define SEGMENT_BOX_OVERLAP_TEST_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SBOT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SBOT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sbot_pkg.sv */
// Shared widths, types and magnitude helpers for the segment/box overlap test.
package sbot_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int HALF_WIDTH  = COORD_WIDTH - 1;
    localparam int MID_WIDTH   = COORD_WIDTH + 2;
    localparam int DIR_WIDTH   = COORD_WIDTH + 1;
    localparam int RAD_WIDTH   = COORD_WIDTH;
    localparam int PROD_WIDTH  = MID_WIDTH + DIR_WIDTH;
    localparam int DIFF_WIDTH  = PROD_WIDTH + 1;
    localparam int TERM_WIDTH  = RAD_WIDTH + DIR_WIDTH;
    localparam int BOUND_WIDTH = TERM_WIDTH + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [HALF_WIDTH-1:0]  half_t;
    typedef logic signed [MID_WIDTH-1:0]   mid_t;
    typedef logic        [MID_WIDTH-1:0]   mid_mag_t;
    typedef logic signed [DIR_WIDTH-1:0]   dir_t;
    typedef logic        [DIR_WIDTH-1:0]   dir_mag_t;
    typedef logic        [RAD_WIDTH-1:0]   rad_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic        [DIFF_WIDTH-1:0]  diff_mag_t;
    typedef logic        [TERM_WIDTH-1:0]  term_t;
    typedef logic        [BOUND_WIDTH-1:0] bound_t;

    // Magnitude of a doubled midpoint offset; the most negative code maps correctly.
    function automatic mid_mag_t mid_abs(input mid_t v);
        return mid_mag_t'(v[MID_WIDTH-1] ? -v : v);
    endfunction

    // Magnitude of a doubled half direction.
    function automatic dir_mag_t dir_abs(input dir_t v);
        return dir_mag_t'(v[DIR_WIDTH-1] ? -v : v);
    endfunction

endpackage

/* rtl/core/segment_box_overlap_test.sv */
// Top level of the segment versus axis-aligned box separating-axis test.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------------
//  s_      | in        | s_valid / s_ready    | segment ends, box centre, half sizes
//  m_      | out       | m_valid / m_ready    | m_overlaps
//
//  One word per cycle, sustained while m_ready does not stall. An accepted word passes, in order, through the
//  input register, offset/direction stage, multiplier stage and result register to m_valid.
//  The twelve products of the multiplier stage (six 26x25-bit, six 24x25-bit) set
//  the critical path.
//  aresetn is synchronous and active low; it empties every stage.
//  A stall on m_ready backs up through the stages one at a time, so s_ready stays
//  high while any stage holds a bubble.
`include "segment_box_overlap_test_macros.svh"

module segment_box_overlap_test
    import sbot_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,

    input  logic   s_valid,
    output logic   s_ready,
    input  coord_t s_seg_start_x,
    input  coord_t s_seg_start_y,
    input  coord_t s_seg_start_z,
    input  coord_t s_seg_end_x,
    input  coord_t s_seg_end_y,
    input  coord_t s_seg_end_z,
    input  coord_t s_box_center_x,
    input  coord_t s_box_center_y,
    input  coord_t s_box_center_z,
    input  half_t  s_half_extent_x,
    input  half_t  s_half_extent_y,
    input  half_t  s_half_extent_z,

    output logic   m_valid,
    input  logic   m_ready,
    output logic   m_overlaps
);

    // ------------------------------------------------------------------
    // Stage occupancy and advance chain. A stage may load when it is
    // empty or when the stage after it is moving on.
    // ------------------------------------------------------------------
    logic in_valid_reg, mdr_valid_reg, prod_valid_reg, out_valid_reg;
    logic adv_in, adv_mdr, adv_prod, adv_out;

    assign adv_out  = !out_valid_reg  || m_ready;
    assign adv_prod = !prod_valid_reg || adv_out;
    assign adv_mdr  = !mdr_valid_reg  || adv_prod;
    assign adv_in   = !in_valid_reg   || adv_mdr;

    assign s_ready  = adv_in;
    assign m_valid  = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            mdr_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (adv_in)   in_valid_reg   <= s_valid;
            if (adv_mdr)  mdr_valid_reg  <= in_valid_reg;
            if (adv_prod) prod_valid_reg <= mdr_valid_reg;
            if (adv_out)  out_valid_reg  <= prod_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input register: capture the raw word on acceptance.
    // ------------------------------------------------------------------
    coord_t start_reg  [3];
    coord_t end_reg    [3];
    coord_t center_reg [3];
    half_t  half_reg   [3];

    always_ff @(posedge aclk) begin
        if (s_valid && adv_in) begin
            start_reg[0]  <= s_seg_start_x;
            start_reg[1]  <= s_seg_start_y;
            start_reg[2]  <= s_seg_start_z;
            end_reg[0]    <= s_seg_end_x;
            end_reg[1]    <= s_seg_end_y;
            end_reg[2]    <= s_seg_end_z;
            center_reg[0] <= s_box_center_x;
            center_reg[1] <= s_box_center_y;
            center_reg[2] <= s_box_center_z;
            half_reg[0]   <= s_half_extent_x;
            half_reg[1]   <= s_half_extent_y;
            half_reg[2]   <= s_half_extent_z;
        end
    end

    // ------------------------------------------------------------------
    // Offset stage: everything doubled so the midpoint needs no halving.
    //   M = a + b - 2c, D = b - a, R = 2r
    // ------------------------------------------------------------------
    mid_t mid_next [3];
    dir_t dir_next [3];
    rad_t rad_next [3];
    mid_t mid_reg  [3];
    dir_t dir_reg  [3];
    rad_t rad_reg  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mid_next[i] = mid_t'(start_reg[i]) + mid_t'(end_reg[i])
                        - (mid_t'(center_reg[i]) <<< 1);
            dir_next[i] = dir_t'(end_reg[i]) - dir_t'(start_reg[i]);
            rad_next[i] = {half_reg[i], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && adv_mdr) begin
            for (int i = 0; i < 3; i++) begin
                mid_reg[i] <= mid_next[i];
                dir_reg[i] <= dir_next[i];
                rad_reg[i] <= rad_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Multiplier stage: world-axis flags here, cross-axis products held
    // inside each cross unit.
    // ------------------------------------------------------------------
    logic [2:0] world_sep_next;
    logic [2:0] world_sep_reg;
    logic       prod_load;

    assign prod_load = mdr_valid_reg && adv_prod;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            world_sep_next[i] = mid_abs(mid_reg[i])
                              > (mid_mag_t'(rad_reg[i]) + mid_mag_t'(dir_abs(dir_reg[i])));
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_load) begin
            world_sep_reg <= world_sep_next;
        end
    end

    logic [2:0] cross_sep;

    // Axis D x e_x: |My*Dz - Mz*Dy| against Ry*|Dz| + Rz*|Dy|
    sbot_cross_axis u_cross_x (
        .aclk      (aclk),
        .load      (prod_load),
        .p         (mid_reg[1]),
        .q         (dir_reg[2]),
        .s         (mid_reg[2]),
        .t         (dir_reg[1]),
        .rq        (rad_reg[1]),
        .rt        (rad_reg[2]),
        .separates (cross_sep[0])
    );

    // Axis D x e_y: |Mz*Dx - Mx*Dz| against Rz*|Dx| + Rx*|Dz|
    sbot_cross_axis u_cross_y (
        .aclk      (aclk),
        .load      (prod_load),
        .p         (mid_reg[2]),
        .q         (dir_reg[0]),
        .s         (mid_reg[0]),
        .t         (dir_reg[2]),
        .rq        (rad_reg[2]),
        .rt        (rad_reg[0]),
        .separates (cross_sep[1])
    );

    // Axis D x e_z: |Mx*Dy - My*Dx| against Rx*|Dy| + Ry*|Dx|
    sbot_cross_axis u_cross_z (
        .aclk      (aclk),
        .load      (prod_load),
        .p         (mid_reg[0]),
        .q         (dir_reg[1]),
        .s         (mid_reg[1]),
        .t         (dir_reg[0]),
        .rq        (rad_reg[0]),
        .rt        (rad_reg[1]),
        .separates (cross_sep[2])
    );

    // ------------------------------------------------------------------
    // Result register: a hit only when no axis separates.
    // ------------------------------------------------------------------
    logic overlaps_next;
    logic overlaps_reg;

    assign overlaps_next = !(|world_sep_reg) && !(|cross_sep);

    always_ff @(posedge aclk) begin
        if (prod_valid_reg && adv_out) begin
            overlaps_reg <= overlaps_next;
        end
    end

    assign m_overlaps = overlaps_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // An empty result stage must open the whole chain back to the input.
    `SBOT_ASSERT_IMPL(a_empty_out_opens_input, aclk, aresetn,
        !out_valid_reg, s_ready, "input held off with empty result stage")
    // A full pipeline with a stalled consumer must hold off the producer.
    `SBOT_ASSERT_IMPL(a_full_stall_blocks, aclk, aresetn,
        in_valid_reg && mdr_valid_reg && prod_valid_reg && out_valid_reg && !m_ready,
        !s_ready, "input taken while every stage is full and stalled")
    // An accepted word must occupy the input register next cycle.
    `SBOT_ASSERT_NEXT(a_accept_fills_input, aclk, aresetn,
        s_valid && s_ready, in_valid_reg, "accepted word lost at input register")

endmodule

/* rtl/core/sbot_cross_axis.sv */
// One cross-product separating axis: registered products, then the bound compare.
module sbot_cross_axis
    import sbot_pkg::*;
(
    input  logic aclk,
    input  logic load,
    input  mid_t p,
    input  dir_t q,
    input  mid_t s,
    input  dir_t t,
    input  rad_t rq,
    input  rad_t rt,
    output logic separates
);

    prod_t pq_reg, st_reg;
    term_t rq_term_reg, rt_term_reg;

    diff_t     diff;
    diff_mag_t diff_mag;
    bound_t    bound;

    // Hold the four products until the stage advances.
    always_ff @(posedge aclk) begin
        if (load) begin
            pq_reg      <= prod_t'(p) * prod_t'(q);
            st_reg      <= prod_t'(s) * prod_t'(t);
            rq_term_reg <= term_t'(rq) * term_t'(dir_abs(q));
            rt_term_reg <= term_t'(rt) * term_t'(dir_abs(t));
        end
    end

    always_comb begin
        diff     = diff_t'(pq_reg) - diff_t'(st_reg);
        diff_mag = diff_mag_t'(diff[DIFF_WIDTH-1] ? -diff : diff);
        bound    = bound_t'(rq_term_reg) + bound_t'(rt_term_reg);
        // Equality touches, so only a strict excess separates.
        separates = diff_mag > diff_mag_t'(bound);
    end

endmodule
